/* rtl/core/flphs_pkg.sv */
// Package for the filtered linear-probe hash set.
// Default sizes, result field widths, request kinds and status codes.
// No dependencies.
`default_nettype none

package flphs_pkg;

	localparam int HASH_BITS_DEF   = 12;
	localparam int FILTER_BITS_DEF = 16;
	localparam int SPILL_SLOTS_DEF = 16;

	localparam int KEY_W    = 64;
	localparam int WORD_W   = 32;
	localparam int SLOT_W   = 13;
	localparam int STATUS_W = 2;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_LOOKUP = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

endpackage

`default_nettype wire

/* rtl/core/flphs_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module flphs_ram #(
	parameter int WIDTH = 32,
	parameter longint unsigned DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/filtered_linear_probe_hash_set_top.sv */
// Filtered linear-probe hash set, top level.
// Depends on flphs_pkg and flphs_ram (prefilter bit RAM and slot store RAM).
`default_nettype none

// Set membership for 64-bit keys. A request beat (kind, key) is taken on a
// rising edge with start high and busy low; kind 0 inserts, kind 1 looks up.
// Each request gives exactly one result beat: done is high for one cycle with
// found, status and slot valid. The receiver cannot stall; results are never
// held back.
// Timing: the request is registered, then S_PROBE checks one slot per step
// until it stops; done is registered from that step and busy drops in the
// same cycle as done, so the next request can be taken then. The slot store
// has one read per cycle, so each probe step reads one slot. An insert of a
// key whose low word is zero answers in the next cycle without probing and
// keeps busy low. Reset: after arst_n releases, both RAMs are cleared one
// entry per cycle over max(2^FILTER_BITS, 2^HASH_BITS + SPILL_SLOTS) addresses
// (65536 by default); busy stays high through the sweep.
module filtered_linear_probe_hash_set_top
	import flphs_pkg::*;
#(
	parameter int HASH_BITS   = HASH_BITS_DEF,
	parameter int FILTER_BITS = FILTER_BITS_DEF,
	parameter int SPILL_SLOTS = SPILL_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                kind,
	input  wire logic [KEY_W-1:0]    key,
	output logic                     done,
	output logic                     found,
	output logic      [STATUS_W-1:0] status,
	output logic      [SLOT_W-1:0]   slot
);

	localparam int TS = (1 << HASH_BITS) + SPILL_SLOTS;
	localparam int AW = $clog2(TS);
	localparam longint unsigned FD = 64'd1 << FILTER_BITS;
	localparam int CW = ((FILTER_BITS > AW) ? FILTER_BITS : AW) + 1;
	localparam longint unsigned CLR_N = (FD > 64'(TS)) ? FD : 64'(TS);
	localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 64'd1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TS - 1);
	localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           clr_q;
	logic                    kind_q;
	logic [WORD_W-1:0]       low_q;
	logic [FILTER_BITS-1:0]  fidx_q;
	logic [AW-1:0]           idx_q;
	logic                    done_q;
	logic                    found_q;
	logic [STATUS_W-1:0]     status_q;
	logic [SLOT_W-1:0]       slot_q;

	logic [WORD_W-1:0]       mix;
	logic [AW-1:0]           home_in;
	logic [FILTER_BITS-1:0]  fidx_in;
	logic [XW-1:0]           idx_x;

	logic                    s_we, f_we;
	logic [AW-1:0]           s_waddr, s_raddr;
	logic [WORD_W-1:0]       s_wdata, s_rdata;
	logic [FILTER_BITS-1:0]  f_waddr, f_raddr;
	logic                    f_rdata;

	logic                    at_last, hit_empty, hit_match, stop, ins_write;
	logic                    clr_slot;

	assign mix     = key[55:24] ^ key[47:16];
	assign home_in = AW'(mix[WORD_W-1 -: HASH_BITS]);
	assign fidx_in = key[KEY_W-1 -: FILTER_BITS];
	assign idx_x   = XW'(idx_q);

	assign at_last   = idx_q == LAST_SLOT;
	assign hit_empty = s_rdata == '0;
	assign hit_match = s_rdata == low_q;

	always_comb begin
		if (kind_q == KIND_LOOKUP) begin
			stop = !f_rdata || at_last || hit_empty || hit_match;
		end else begin
			stop = at_last || hit_empty;
		end
	end

	assign ins_write = (state_q == S_PROBE) && (kind_q == KIND_INSERT) && !at_last && hit_empty;
	assign clr_slot  = (state_q == S_CLEAR) && (clr_q < CW'(TS));

	assign s_we    = clr_slot || ins_write;
	assign s_waddr = (state_q == S_CLEAR) ? clr_q[AW-1:0] : idx_q;
	assign s_wdata = (state_q == S_CLEAR) ? '0 : low_q;
	assign s_raddr = (state_q == S_PROBE) ? idx_q + AW'(1) : home_in;

	assign f_we    = (state_q == S_CLEAR) || ins_write;
	assign f_waddr = (state_q == S_CLEAR) ? clr_q[FILTER_BITS-1:0] : fidx_q;
	assign f_raddr = (state_q == S_PROBE) ? fidx_q : fidx_in;

	flphs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (64'(TS))
	) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	flphs_ram #(
		.WIDTH (1),
		.DEPTH (FD)
	) u_filter_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (state_q != S_CLEAR),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			kind_q   <= 1'b0;
			low_q    <= '0;
			fidx_q   <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			status_q <= ST_OK;
			slot_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					done_q <= 1'b0;
					clr_q  <= clr_q + CW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						kind_q <= kind;
						low_q  <= key[WORD_W-1:0];
						fidx_q <= fidx_in;
						idx_q  <= home_in;
						if (kind == KIND_INSERT && key[WORD_W-1:0] == '0) begin
							done_q   <= 1'b1;
							found_q  <= 1'b0;
							status_q <= ST_ZERO;
							slot_q   <= '0;
						end else begin
							done_q  <= 1'b0;
							state_q <= S_PROBE;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				S_PROBE: begin
					done_q <= stop;
					if (stop) begin
						slot_q  <= idx_x[SLOT_W-1:0];
						state_q <= S_IDLE;
						if (kind_q == KIND_LOOKUP) begin
							found_q  <= f_rdata && !hit_empty;
							status_q <= ST_OK;
						end else begin
							found_q  <= 1'b0;
							status_q <= at_last ? ST_FULL : ST_OK;
						end
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign found  = found_q;
	assign status = status_q;
	assign slot   = slot_q;

endmodule

`default_nettype wire
